>>> design/tcfs_pkg.sv
// Shared types and constants for the triangle cull and flat shade pipeline.
// No dependencies; imported by every module of the block.
package tcfs_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int NORM_W    = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int DIR_W     = COORD_W + 4;
    localparam int PDOT_W    = NORM_W + DIR_W;
    localparam int DOT_W     = PDOT_W + 2;
    localparam int NORM_BITS = 12;
    localparam int BLEN_W    = $clog2(MAG_W + 1);
    localparam int K_W       = $clog2(MAG_W - NORM_BITS + 1);
    localparam int SQ_W      = 2 * NORM_BITS;
    localparam int LEN2_W    = SQ_W + 2;
    localparam int S_W       = NORM_BITS + 3;
    localparam int LNUM_W    = 14;
    localparam int A_W       = LNUM_W + S_W - 1;
    localparam int R_W       = 2 * A_W;
    localparam int L_W       = LEN2_W + LNUM_W;
    localparam int Q_W       = 8;
    localparam int Q2_W      = 2 * Q_W;
    localparam int INT_W     = Q_W + 1;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;

    localparam logic [63:0] DEGEN_LIMIT =
        ((64'd1 << (4 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;
    localparam logic [LNUM_W-1:0] LIGHT_NUM    = 14'd13848;
    localparam logic [LNUM_W-1:0] LIGHT_DEN_SQ = 14'd15625;
    localparam logic [Q_W-1:0]    AMBIENT_Q8   = 8'd64;
    localparam logic [Q_W-1:0]    DIFFUSE_MAX  = 8'd192;
    localparam logic [COLOR_W-1:0] BASE_RESET  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CULL_NONE  = 2'd0,
        CULL_DEGEN = 2'd1,
        CULL_BACK  = 2'd2
    } cull_t;

    typedef enum logic [1:0] {
        REG_CAMERA_X   = 2'd0,
        REG_CAMERA_Y   = 2'd1,
        REG_CAMERA_Z   = 2'd2,
        REG_BASE_COLOR = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] ax;
    } tri_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic signed [DIR_W-1:0]  dx;
        logic signed [DIR_W-1:0]  dy;
        logic signed [DIR_W-1:0]  dz;
    } norm_t;

    typedef struct packed {
        cull_t                code;
        logic [NORM_BITS-1:0] mx;
        logic [NORM_BITS-1:0] my;
        logic [NORM_BITS-1:0] mz;
        logic                 sx;
        logic                 sy;
        logic                 sz;
    } face_t;

    typedef struct packed {
        cull_t           code;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } res_t;

endpackage

>>> design/tcfs_geom.sv
// Edge vectors, cross product and camera direction: three register stages.
// Depends on tcfs_pkg.
module tcfs_geom
    import tcfs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      pipe_en,
    input  logic                      in_valid,
    input  tri_t                      tri_in,
    input  logic signed [COORD_W-1:0] cam_x,
    input  logic signed [COORD_W-1:0] cam_y,
    input  logic signed [COORD_W-1:0] cam_z,
    output logic                      out_valid,
    output norm_t                     norm_out
);

    logic v1_reg, v2_reg, v3_reg;
    logic signed [EDGE_W-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [DIR_W-1:0]  d1x_reg, d1y_reg, d1z_reg, d2x_reg, d2y_reg, d2z_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    norm_t norm_reg;

    logic signed [EDGE_W-1:0] e1x_next, e1y_next, e1z_next, e2x_next, e2y_next, e2z_next;
    logic signed [DIR_W-1:0]  dx_next, dy_next, dz_next;
    norm_t norm_next;

    always_comb begin
        e1x_next = EDGE_W'(tri_in.bx) - EDGE_W'(tri_in.ax);
        e1y_next = EDGE_W'(tri_in.by_coord) - EDGE_W'(tri_in.ay);
        e1z_next = EDGE_W'(tri_in.bz) - EDGE_W'(tri_in.az);
        e2x_next = EDGE_W'(tri_in.cx) - EDGE_W'(tri_in.ax);
        e2y_next = EDGE_W'(tri_in.cy) - EDGE_W'(tri_in.ay);
        e2z_next = EDGE_W'(tri_in.cz) - EDGE_W'(tri_in.az);
        dx_next  = (DIR_W'(cam_x) <<< 1) + DIR_W'(cam_x)
                 - (DIR_W'(tri_in.ax) + DIR_W'(tri_in.bx) + DIR_W'(tri_in.cx));
        dy_next  = (DIR_W'(cam_y) <<< 1) + DIR_W'(cam_y)
                 - (DIR_W'(tri_in.ay) + DIR_W'(tri_in.by_coord) + DIR_W'(tri_in.cy));
        dz_next  = (DIR_W'(cam_z) <<< 1) + DIR_W'(cam_z)
                 - (DIR_W'(tri_in.az) + DIR_W'(tri_in.bz) + DIR_W'(tri_in.cz));
        norm_next.nx = NORM_W'(p0_reg) - NORM_W'(p1_reg);
        norm_next.ny = NORM_W'(p2_reg) - NORM_W'(p3_reg);
        norm_next.nz = NORM_W'(p4_reg) - NORM_W'(p5_reg);
        norm_next.dx = d2x_reg;
        norm_next.dy = d2y_reg;
        norm_next.dz = d2z_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            e1x_reg  <= e1x_next;
            e1y_reg  <= e1y_next;
            e1z_reg  <= e1z_next;
            e2x_reg  <= e2x_next;
            e2y_reg  <= e2y_next;
            e2z_reg  <= e2z_next;
            d1x_reg  <= dx_next;
            d1y_reg  <= dy_next;
            d1z_reg  <= dz_next;
            p0_reg   <= PROD_W'(e1y_reg) * PROD_W'(e2z_reg);
            p1_reg   <= PROD_W'(e1z_reg) * PROD_W'(e2y_reg);
            p2_reg   <= PROD_W'(e1z_reg) * PROD_W'(e2x_reg);
            p3_reg   <= PROD_W'(e1x_reg) * PROD_W'(e2z_reg);
            p4_reg   <= PROD_W'(e1x_reg) * PROD_W'(e2y_reg);
            p5_reg   <= PROD_W'(e1y_reg) * PROD_W'(e2x_reg);
            d2x_reg  <= d1x_reg;
            d2y_reg  <= d1y_reg;
            d2z_reg  <= d1z_reg;
            norm_reg <= norm_next;
        end
    end

    assign out_valid = v3_reg;
    assign norm_out  = norm_reg;

endmodule

>>> design/tcfs_cull.sv
// Facing and degenerate tests, then normal scaling to 12-bit magnitudes.
// Four register stages; depends on tcfs_pkg.
module tcfs_cull
    import tcfs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  pipe_en,
    input  logic  in_valid,
    input  norm_t norm_in,
    output logic  out_valid,
    output face_t face_out
);

    function automatic logic [MAG_W-1:0] mag_of(logic signed [NORM_W-1:0] v);
        logic [NORM_W-1:0] a;
        a = v[NORM_W-1] ? NORM_W'(-v) : NORM_W'(v);
        return a[MAG_W-1:0];
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [MAG_W-1:0] mx1_reg, my1_reg, mz1_reg, mx2_reg, my2_reg, mz2_reg;
    logic [MAG_W-1:0] mx3_reg, my3_reg, mz3_reg, m2_reg;
    logic sx1_reg, sy1_reg, sz1_reg, sx2_reg, sy2_reg, sz2_reg, sx3_reg, sy3_reg, sz3_reg;
    logic signed [PDOT_W-1:0] px_reg, py_reg, pz_reg;
    logic degen2_reg, front2_reg;
    cull_t code3_reg;
    logic [K_W-1:0] k3_reg;
    face_t face_reg;

    logic signed [DOT_W-1:0] dot;
    logic [MAG_W-1:0] m_next;
    logic [LEN2_W-1:0] len2_small;
    logic degen_next;
    logic [BLEN_W-1:0] blen;
    logic [K_W-1:0] k_next;
    cull_t code_next;
    face_t face_next;

    always_comb begin
        dot = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        m_next = (mx1_reg > my1_reg) ? mx1_reg : my1_reg;
        if (mz1_reg > m_next) begin
            m_next = mz1_reg;
        end
        len2_small = LEN2_W'(mx1_reg[NORM_BITS-1:0] * mx1_reg[NORM_BITS-1:0])
                   + LEN2_W'(my1_reg[NORM_BITS-1:0] * my1_reg[NORM_BITS-1:0])
                   + LEN2_W'(mz1_reg[NORM_BITS-1:0] * mz1_reg[NORM_BITS-1:0]);
        degen_next = (mx1_reg[MAG_W-1:NORM_BITS] == '0)
                  && (my1_reg[MAG_W-1:NORM_BITS] == '0)
                  && (mz1_reg[MAG_W-1:NORM_BITS] == '0)
                  && (64'(len2_small) < DEGEN_LIMIT);

        blen = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m2_reg[i]) begin
                blen = BLEN_W'(i + 1);
            end
        end
        k_next = (blen > BLEN_W'(NORM_BITS)) ? K_W'(blen - BLEN_W'(NORM_BITS)) : '0;
        if (degen2_reg) begin
            code_next = CULL_DEGEN;
        end else if (!front2_reg) begin
            code_next = CULL_BACK;
        end else begin
            code_next = CULL_NONE;
        end

        face_next.code = code3_reg;
        face_next.mx   = NORM_BITS'(mx3_reg >> k3_reg);
        face_next.my   = NORM_BITS'(my3_reg >> k3_reg);
        face_next.mz   = NORM_BITS'(mz3_reg >> k3_reg);
        face_next.sx   = sx3_reg;
        face_next.sy   = sy3_reg;
        face_next.sz   = sz3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mx1_reg    <= mag_of(norm_in.nx);
            my1_reg    <= mag_of(norm_in.ny);
            mz1_reg    <= mag_of(norm_in.nz);
            sx1_reg    <= norm_in.nx[NORM_W-1];
            sy1_reg    <= norm_in.ny[NORM_W-1];
            sz1_reg    <= norm_in.nz[NORM_W-1];
            px_reg     <= PDOT_W'(norm_in.nx) * PDOT_W'(norm_in.dx);
            py_reg     <= PDOT_W'(norm_in.ny) * PDOT_W'(norm_in.dy);
            pz_reg     <= PDOT_W'(norm_in.nz) * PDOT_W'(norm_in.dz);
            mx2_reg    <= mx1_reg;
            my2_reg    <= my1_reg;
            mz2_reg    <= mz1_reg;
            sx2_reg    <= sx1_reg;
            sy2_reg    <= sy1_reg;
            sz2_reg    <= sz1_reg;
            m2_reg     <= m_next;
            degen2_reg <= degen_next;
            front2_reg <= !dot[DOT_W-1] && (dot != '0);
            mx3_reg    <= mx2_reg;
            my3_reg    <= my2_reg;
            mz3_reg    <= mz2_reg;
            sx3_reg    <= sx2_reg;
            sy3_reg    <= sy2_reg;
            sz3_reg    <= sz2_reg;
            k3_reg     <= k_next;
            code3_reg  <= code_next;
            face_reg   <= face_next;
        end
    end

    assign out_valid = v4_reg;
    assign face_out  = face_reg;

endmodule

>>> design/tcfs_light.sv
// Lambert term by an eight-stage bitwise search, then ambient and color scale.
// Twelve register stages; depends on tcfs_pkg.
module tcfs_light
    import tcfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pipe_en,
    input  logic               in_valid,
    input  face_t              face_in,
    input  logic [COLOR_W-1:0] base_color,
    output logic               out_valid,
    output res_t               res_out
);

    localparam int SRCH_N = Q_W;

    logic v1_reg, v2_reg;
    cull_t code1_reg, code2_reg;
    logic [LEN2_W-1:0] len2_reg;
    logic signed [S_W-1:0] s_reg;
    logic [A_W-1:0] a_reg;
    logic [L_W-1:0] l2_reg;
    logic spos2_reg;

    logic [SRCH_N:0]   sv_reg;
    cull_t             scode_reg [SRCH_N+1];
    logic              spos_reg  [SRCH_N+1];
    logic [L_W-1:0]    sl_reg    [SRCH_N+1];
    logic [R_W-1:0]    sr_reg    [SRCH_N+1];
    logic [Q_W-1:0]    sq_reg    [SRCH_N+1];
    logic [Q2_W-1:0]   sq2_reg   [SRCH_N+1];

    res_t res_reg;
    logic out_v_reg;

    logic signed [S_W-1:0] s_next;
    logic signed [S_W-1:0] npx, npy, npz;
    logic [LEN2_W-1:0] len2_next;
    logic [Q_W-1:0] qc;
    logic [INT_W-1:0] inten;
    logic [2*CH_W:0] pr, pg, pb;
    res_t res_next;

    always_comb begin
        npx = face_in.sx ? -S_W'(face_in.mx) : S_W'(face_in.mx);
        npy = face_in.sy ? -S_W'(face_in.my) : S_W'(face_in.my);
        npz = face_in.sz ? -S_W'(face_in.mz) : S_W'(face_in.mz);
        s_next = npx + npy - npz;
        len2_next = LEN2_W'(face_in.mx * face_in.mx)
                  + LEN2_W'(face_in.my * face_in.my)
                  + LEN2_W'(face_in.mz * face_in.mz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            sv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            sv_reg    <= {sv_reg[SRCH_N-1:0], v2_reg};
            out_v_reg <= sv_reg[SRCH_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            code1_reg    <= face_in.code;
            len2_reg     <= len2_next;
            s_reg        <= s_next;
            code2_reg    <= code1_reg;
            spos2_reg    <= !s_reg[S_W-1] && (s_reg != '0);
            a_reg        <= (!s_reg[S_W-1] && (s_reg != '0))
                          ? A_W'(LIGHT_NUM) * A_W'(s_reg[S_W-2:0]) : '0;
            l2_reg       <= L_W'(LIGHT_DEN_SQ) * L_W'(len2_reg);
            scode_reg[0] <= code2_reg;
            spos_reg[0]  <= spos2_reg;
            sl_reg[0]    <= l2_reg;
            sr_reg[0]    <= R_W'(a_reg) * R_W'(a_reg);
            sq_reg[0]    <= '0;
            sq2_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= SRCH_N; j++) begin : g_srch
        localparam int B = SRCH_N - j;
        logic [Q2_W:0] t2;
        logic [R_W-1:0] lhs;
        logic take;

        always_comb begin
            t2   = (Q2_W+1)'(sq2_reg[j-1]) + ((Q2_W+1)'(sq_reg[j-1]) << (B + 1))
                 + ((Q2_W+1)'(1) << (2 * B));
            lhs  = R_W'(t2[Q2_W-1:0]) * R_W'(sl_reg[j-1]);
            take = (lhs <= sr_reg[j-1]);
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                scode_reg[j] <= scode_reg[j-1];
                spos_reg[j]  <= spos_reg[j-1];
                sl_reg[j]    <= sl_reg[j-1];
                sr_reg[j]    <= sr_reg[j-1];
                sq_reg[j]    <= take ? (sq_reg[j-1] | Q_W'(1 << B)) : sq_reg[j-1];
                sq2_reg[j]   <= take ? t2[Q2_W-1:0] : sq2_reg[j-1];
            end
        end
    end

    always_comb begin
        if (!spos_reg[SRCH_N]) begin
            qc = '0;
        end else if (sq_reg[SRCH_N] > DIFFUSE_MAX) begin
            qc = DIFFUSE_MAX;
        end else begin
            qc = sq_reg[SRCH_N];
        end
        inten = INT_W'(AMBIENT_Q8) + INT_W'(qc);
        pr = (2*CH_W+1)'(base_color[CH_W-1:0]) * (2*CH_W+1)'(inten);
        pg = (2*CH_W+1)'(base_color[2*CH_W-1:CH_W]) * (2*CH_W+1)'(inten);
        pb = (2*CH_W+1)'(base_color[3*CH_W-1:2*CH_W]) * (2*CH_W+1)'(inten);
        res_next.code = scode_reg[SRCH_N];
        if (scode_reg[SRCH_N] == CULL_NONE) begin
            res_next.red   = pr[2*CH_W-1:CH_W];
            res_next.green = pg[2*CH_W-1:CH_W];
            res_next.blue  = pb[2*CH_W-1:CH_W];
        end else begin
            res_next.red   = '0;
            res_next.green = '0;
            res_next.blue  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_v_reg;
    assign res_out   = res_reg;

endmodule

>>> design/triangle_cull_flat_shade_top.sv
// Top level of the triangle cull and flat shade pipeline: input skid word,
// configuration registers and the three pipeline sections; uses tcfs_pkg.
//
// Usage:
//   s_ channel: one triangle per word, nine signed Q8.8 coordinates in s_tdata.
//   m_ channel: one word per triangle; m_tuser carries the cull code
//   (drawn, degenerate, back-facing), m_tdata the shaded color, zero if culled.
//   Configuration: write camera x/y/z and base color through cfg_wr_en,
//   cfg_addr and cfg_wdata while no triangle is in flight.
// Pipeline depth: 3 geometry, 4 cull and 12 lighting stages, 8 of them
//   the Lambert search.
// Throughput: one triangle per cycle unless stalled; every stage holds one word.
// Reset: aresetn low clears all valid bits and the skid word; camera resets
//   to the origin and base color to white.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds; one
//   more word is taken into the skid register, then s_tready drops until the pipe moves.
module triangle_cull_flat_shade_top
    import tcfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [9*COORD_W-1:0] s_tdata,   // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COLOR_W-1:0]   m_tdata,   // shade_red, shade_green, shade_blue
    output logic [1:0]           m_tuser,   // cull_code
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [COLOR_W-1:0]   cfg_wdata
);

    logic signed [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [COLOR_W-1:0] base_color_reg;
    logic skid_valid_reg;
    tri_t skid_reg;

    logic pipe_en;
    logic pipe_in_valid;
    tri_t pipe_in;
    logic geom_valid, cull_valid, light_valid;
    norm_t norm;
    face_t face;
    res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg      <= '0;
            cam_y_reg      <= '0;
            cam_z_reg      <= '0;
            base_color_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_CAMERA_X:   cam_x_reg      <= cfg_wdata[COORD_W-1:0];
                REG_CAMERA_Y:   cam_y_reg      <= cfg_wdata[COORD_W-1:0];
                REG_CAMERA_Z:   cam_z_reg      <= cfg_wdata[COORD_W-1:0];
                REG_BASE_COLOR: base_color_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign pipe_en       = !light_valid || m_tready;
    assign s_tready      = !skid_valid_reg;
    assign pipe_in_valid = skid_valid_reg || s_tvalid;
    assign pipe_in       = skid_valid_reg ? skid_reg : tri_t'(s_tdata);

    // hold a word in the skid register while the pipe is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_reg <= tri_t'(s_tdata);
        end
    end

    tcfs_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (pipe_in_valid),
        .tri_in    (pipe_in),
        .cam_x     (cam_x_reg),
        .cam_y     (cam_y_reg),
        .cam_z     (cam_z_reg),
        .out_valid (geom_valid),
        .norm_out  (norm)
    );

    tcfs_cull u_cull (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (geom_valid),
        .norm_in   (norm),
        .out_valid (cull_valid),
        .face_out  (face)
    );

    tcfs_light u_light (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_en    (pipe_en),
        .in_valid   (cull_valid),
        .face_in    (face),
        .base_color (base_color_reg),
        .out_valid  (light_valid),
        .res_out    (res)
    );

    assign m_tvalid = light_valid;
    assign m_tuser  = res.code;
    assign m_tdata  = {res.blue, res.green, res.red};

`ifndef ASSERT_OFF
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !pipe_en |=> skid_valid_reg)
        else $error("skid word lost on stall");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && pipe_en |=> !skid_valid_reg)
        else $error("skid word not drained when pipe advanced");

    a_cull_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != CULL_NONE) |-> (m_tdata == '0))
        else $error("culled triangle carries color");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for triangle_cull_flat_shade_top: streams random and directed triangles,
// rewrites camera and base color between phases and checks every word against a local model.
// Depends on tcfs_pkg and the RTL top level only.
module testbench;
    import tcfs_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [9*COORD_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [COLOR_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_addr = REG_CAMERA_X;
    logic [COLOR_W-1:0]   cfg_wdata = '0;

    triangle_cull_flat_shade_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    tri_t        tri_pending[$];
    res_t        shade_expected[$];
    logic [15:0] cam_x = 16'd0, cam_y = 16'd0, cam_z = 16'd0;
    logic [23:0] base_rgb = 24'hFFFFFF;
    int          mismatches = 0;
    int          words_seen = 0;
    int          cycles = 0;
    bit          no_gaps = 1'b0;

    function automatic res_t shade_tri(tri_t t);
        longint      e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz, dot, m, s, len2;
        longint      n[3], mg[3], np[3];
        logic [127:0] rhs, lhs, tq;
        longint      q, inten;
        int          k;
        res_t        r;
        r = '0;
        e1x = longint'(t.bx) - t.ax; e1y = longint'(t.by_coord) - t.ay;
        e1z = longint'(t.bz) - t.az;
        e2x = longint'(t.cx) - t.ax; e2y = longint'(t.cy) - t.ay; e2z = longint'(t.cz) - t.az;
        n[0] = e1y * e2z - e1z * e2y;
        n[1] = e1z * e2x - e1x * e2z;
        n[2] = e1x * e2y - e1y * e2x;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = n[i] < 0 ? -n[i] : n[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m < 4096) begin
            len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
            if (len2 < 43) begin
                r.code = CULL_DEGEN;
                return r;
            end
        end
        dx = 3 * longint'($signed(cam_x)) - (longint'(t.ax) + t.bx + t.cx);
        dy = 3 * longint'($signed(cam_y)) - (longint'(t.ay) + t.by_coord + t.cy);
        dz = 3 * longint'($signed(cam_z)) - (longint'(t.az) + t.bz + t.cz);
        dot = n[0] * dx + n[1] * dy + n[2] * dz;
        if (dot <= 0) begin
            r.code = CULL_BACK;
            return r;
        end
        k = 0;
        while ((m >>> k) >= 4096) k++;
        for (int i = 0; i < 3; i++) np[i] = n[i] < 0 ? -(mg[i] >>> k) : (mg[i] >>> k);
        len2 = np[0] * np[0] + np[1] * np[1] + np[2] * np[2];
        s = np[0] + np[1] - np[2];
        q = 0;
        if (s > 0) begin
            rhs = 128'(110784) * 128'(s);
            rhs = rhs * rhs;
            for (int b = 128; b != 0; b = b >> 1) begin
                tq = 128'(q | b) * 128'd1000;
                lhs = tq * tq * 128'(len2);
                if (lhs <= rhs) q = q | b;
            end
            if (q > 192) q = 192;
        end
        inten = 64 + q;
        r.code  = CULL_NONE;
        r.red   = 8'((longint'(base_rgb[7:0]) * inten) >> 8);
        r.green = 8'((longint'(base_rgb[15:8]) * inten) >> 8);
        r.blue  = 8'((longint'(base_rgb[23:16]) * inten) >> 8);
        return r;
    endfunction

    // sender
    tri_t cur_tri;
    int   s_gap = 0;
    always @(posedge aclk) begin
        logic nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                shade_expected.push_back(shade_tri(cur_tri));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (tri_pending.size() > 0) begin
                    cur_tri = tri_pending.pop_front();
                    s_tdata <= cur_tri;
                    nxt_valid = 1'b1;
                    s_gap = no_gaps ? 0 : $urandom_range(0, 18);
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // long receiver hold, counted on its own
    int hold_left = 0;
    int hold_words = 0;
    bit hold_on = 1'b0;
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) hold_words++;
        if (hold_left > 0) begin
            hold_left--;
        end else if (m_tvalid && m_tready && (hold_words == 60 || hold_words == 900)) begin
            hold_left = 400;
        end
        hold_on <= (hold_left > 0);
    end

    // receiver
    int r_stall = 0;
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (shade_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: tuser=%0d tdata=%h", m_tuser, m_tdata);
                end else begin
                    want = shade_expected.pop_front();
                    if (m_tuser !== want.code || m_tdata[7:0] !== want.red ||
                        m_tdata[15:8] !== want.green || m_tdata[23:16] !== want.blue) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp code=%0d rgb=%h %h %h, got code=%0d rgb=%h %h %h",
                                     want.code, want.red, want.green, want.blue,
                                     m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                    end
                end
                r_stall = no_gaps ? 0 : $urandom_range(0, 18);
            end
            if (hold_on) begin
                m_tready <= 1'b0;
            end else if (r_stall > 0) begin
                r_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 1000000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CAMERA_X:   cam_x = val[15:0];
            REG_CAMERA_Y:   cam_y = val[15:0];
            REG_CAMERA_Z:   cam_z = val[15:0];
            REG_BASE_COLOR: base_rgb = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_t t;
        t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
        t.bx = 16'(bx); t.by_coord = 16'(by); t.bz = 16'(bz);
        t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
        tri_pending.push_back(t);
    endtask

    task automatic add_random_tri();
        tri_t t;
        int   kind, ox, oy, oz, sp, f;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            t = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        end else begin
            ox = int'($signed(16'($urandom)) / 2);
            oy = int'($signed(16'($urandom)) / 2);
            oz = int'($signed(16'($urandom)) / 2);
            sp = kind < 70 ? $urandom_range(1, 2000) : $urandom_range(1, 8);
            t.ax = 16'(ox); t.ay = 16'(oy); t.az = 16'(oz);
            t.bx = 16'(ox + $urandom_range(0, 2 * sp) - sp);
            t.by_coord = 16'(oy + $urandom_range(0, 2 * sp) - sp);
            t.bz = 16'(oz + $urandom_range(0, 2 * sp) - sp);
            if (kind >= 88) begin
                f = $urandom_range(0, 3) - 1;
                t.cx = 16'(ox + f * (t.bx - ox) + $urandom_range(0, 2) - 1);
                t.cy = 16'(oy + f * (t.by_coord - oy) + $urandom_range(0, 2) - 1);
                t.cz = 16'(oz + f * (t.bz - oz) + $urandom_range(0, 2) - 1);
            end else begin
                t.cx = 16'(ox + $urandom_range(0, 2 * sp) - sp);
                t.cy = 16'(oy + $urandom_range(0, 2 * sp) - sp);
                t.cz = 16'(oz + $urandom_range(0, 2 * sp) - sp);
            end
        end
        tri_pending.push_back(t);
    endtask

    task automatic drain();
        wait (tri_pending.size() == 0 && !s_tvalid && shade_expected.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return 24'h008000;
            1: return 24'h007FFF;
            2: return 24'h000000;
            default: return 24'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(0, 0, 0, 7, 0, 0, 0, 7, 0);
        add_tri(0, 0, 0, 0, 7, 0, 7, 0, 0);
        add_tri(256, 0, 0, 0, 256, 0, 0, 0, 256);
        add_tri(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768);
        add_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
        add_tri(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
        add_tri(512, 512, -512, 768, 512, -256, 512, 768, -256);
        add_tri(512, 512, -512, 512, 768, -256, 768, 512, -256);
        add_tri(1000, 1000, 1000, 1200, 1000, 900, 1000, 1300, 1100);
        add_tri(-2000, 300, 5000, -1800, 300, 5000, -2000, 500, 5000);
        add_tri(-2000, 300, 5000, -2000, 500, 5000, -1800, 300, 5000);
        add_tri(0, 0, -20000, 20000, 0, 0, 0, 20000, 0);
        add_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
        add_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            no_gaps = (ph % 3 == 2);
            write_reg(REG_CAMERA_X, pick_coord());
            write_reg(REG_CAMERA_Y, pick_coord());
            write_reg(REG_CAMERA_Z, pick_coord());
            case (ph % 4)
                0: write_reg(REG_BASE_COLOR, 24'h000000);
                1: write_reg(REG_BASE_COLOR, 24'hFFFFFF);
                default: write_reg(REG_BASE_COLOR, 24'($urandom));
            endcase
            for (int i = 0; i < 170; i++) add_random_tri();
            drain();
        end

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
